[design/vqdm_pkg.sv]
package vqdm_pkg;

  localparam int unsigned DescW             = 8;
  localparam int unsigned NumDesc           = 1 << DescW;
  localparam int unsigned AvailW            = 16;
  localparam int unsigned CountW            = 9;
  localparam int unsigned CfgW              = 4;
  localparam int unsigned DefaultQueueDepth = 256;

  localparam logic [AvailW-1:0] AvailLast = 16'hFFFF;
  localparam logic [CfgW-1:0]   SizeLog2Max = 4'd8;

  typedef enum logic [1:0] {
    KindAlloc  = 2'd0,
    KindFree   = 2'd1,
    KindSubmit = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoFree   = 2'd1,
    StatusFreeIdle = 2'd2
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [DescW-1:0] desc_in;
  } vqdm_in_t;

  typedef struct packed {
    logic [DescW-1:0]  desc_out;
    status_e           status;
    logic [DescW-1:0]  ring_slot;
    logic [AvailW-1:0] avail_count;
    logic [CountW-1:0] free_count;
  } vqdm_out_t;

endpackage

[design/virtqueue_descriptor_manager_core.sv]
// Split-virtqueue descriptor manager. Each transfer on the input channel is one
// operation (allocate, free or submit) and gives exactly one result transfer.
// One operation is taken every clock cycle while the result is not stalled; it
// waits in the input register and its result is offered from the output register.
// A stalled result holds back at most one further item in the input register.
// The free list lives in a next-pointer memory with one registered read port; the
// successor of the free head is prefetched so back-to-back allocations do not stall.
// Valid bits give the reset contents of the table at once, so no clearing pass follows
// reset. The queue size register may only be written while no operation is in flight.
module virtqueue_descriptor_manager_core import vqdm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefaultQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vqdm_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vqdm_out_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned TableDepth = (QUEUE_DEPTH < NumDesc) ? QUEUE_DEPTH : NumDesc;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam logic [CountW-1:0] SizeCap = CountW'(TableDepth);
  localparam logic [IdxW-1:0]   ModLast = IdxW'(TableDepth - 1);

  // descriptor number to table row
  logic [IdxW-1:0] mod_lut [NumDesc];
  for (genvar g = 0; g < NumDesc; g++) begin : g_mod
    localparam int unsigned ModVal = g % TableDepth;
    assign mod_lut[g] = IdxW'(ModVal);
  end

  // configuration
  logic [CountW-1:0] size_q, size_d, pow_w;
  logic              use_cap_q, use_cap_d;

  always_comb begin
    pow_w = (cfg_wdata_i >= SizeLog2Max) ? SizeCap | CountW'(NumDesc)
                                         : (CountW'(1) << cfg_wdata_i);
    if (cfg_wdata_i >= SizeLog2Max) begin
      pow_w = CountW'(NumDesc);
    end
    if (pow_w >= SizeCap) begin
      size_d    = SizeCap;
      use_cap_d = 1'b1;
    end else begin
      size_d    = pow_w;
      use_cap_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SizeCap;
      use_cap_q <= 1'b1;
    end else if (cfg_we_i) begin
      size_q    <= size_d;
      use_cap_q <= use_cap_d;
    end
  end

  // handshake
  logic      in_vld_q, out_vld_q, advance;
  vqdm_in_t  in_q;
  vqdm_out_t out_q, res_d;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // list state
  logic [DescW-1:0]  head_q, head_d;
  logic [DescW-1:0]  link_byp_q, link_byp_d, link_cur, tbl_rd_data;
  logic              use_byp_q, use_byp_d;
  logic [CountW-1:0] in_use_q, in_use_d;
  logic [AvailW-1:0] avail_q, avail_d;
  logic [IdxW-1:0]   avail_mod_q, avail_mod_d;
  logic              tbl_wr_en;
  logic [DescW-1:0]  slot_mask;

  // successor of the head: bypass value, or the prefetched table read
  assign link_cur  = use_byp_q ? link_byp_q : tbl_rd_data;
  assign slot_mask = DescW'(size_q - CountW'(1));

  always_comb begin
    head_d      = head_q;
    in_use_d    = in_use_q;
    avail_d     = avail_q;
    avail_mod_d = avail_mod_q;
    link_byp_d  = link_cur;
    use_byp_d   = 1'b1;
    tbl_wr_en   = 1'b0;

    res_d.desc_out    = in_q.desc_in;
    res_d.status      = StatusOk;
    res_d.ring_slot   = '0;
    res_d.avail_count = avail_q;
    res_d.free_count  = '0;

    if (advance) begin
      case (in_q.kind)
        KindAlloc: begin
          if (in_use_q >= size_q) begin
            res_d.status   = StatusNoFree;
            res_d.desc_out = '0;
          end else begin
            res_d.desc_out = head_q;
            head_d         = link_cur;
            in_use_d       = in_use_q + CountW'(1);
            // new head's successor arrives from the table next cycle
            use_byp_d      = 1'b0;
          end
        end
        KindFree: begin
          if (in_use_q == '0) begin
            res_d.status = StatusFreeIdle;
          end else begin
            tbl_wr_en  = 1'b1;
            head_d     = in_q.desc_in;
            in_use_d   = in_use_q - CountW'(1);
            link_byp_d = head_q;
          end
        end
        KindSubmit: begin
          res_d.ring_slot = use_cap_q ? DescW'(avail_mod_q) : (avail_q[DescW-1:0] & slot_mask);
          avail_d         = avail_q + AvailW'(1);
          if (avail_q == AvailLast || avail_mod_q == ModLast) begin
            avail_mod_d = '0;
          end else begin
            avail_mod_d = avail_mod_q + IdxW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    res_d.avail_count = avail_d;
    res_d.free_count  = (in_use_d >= size_q) ? '0 : size_q - in_use_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      link_byp_q  <= DescW'(1);
      use_byp_q   <= 1'b1;
      in_use_q    <= '0;
      avail_q     <= '0;
      avail_mod_q <= '0;
    end else begin
      head_q      <= head_d;
      link_byp_q  <= link_byp_d;
      use_byp_q   <= use_byp_d;
      in_use_q    <= in_use_d;
      avail_q     <= avail_d;
      avail_mod_q <= avail_mod_d;
    end
  end

  vqdm_link_table #(
    .Depth (TableDepth),
    .IdxW  (IdxW)
  ) u_link_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_idx_i  (mod_lut[in_q.desc_in]),
    .wr_data_i (head_q),
    .rd_idx_i  (mod_lut[link_cur]),
    .rd_data_o (tbl_rd_data)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_use_q != $past(in_use_q)) |-> $past(advance))
    else $error("in-use count moved without a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register not loaded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.kind == KindAlloc && in_use_q >= size_q)
    |=> (head_q == $past(head_q) && in_use_q == $past(in_use_q)))
    else $error("refused allocation changed the free list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !use_byp_q |-> $past(advance && in_q.kind == KindAlloc))
    else $error("table read used outside an allocation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    avail_mod_q <= ModLast)
    else $error("ring slot counter out of range");

endmodule

[design/vqdm_link_table.sv]
module vqdm_link_table import vqdm_pkg::*; #(
  parameter int unsigned Depth = DefaultQueueDepth,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  input  logic [DescW-1:0] wr_data_i,
  input  logic [IdxW-1:0]  rd_idx_i,
  output logic [DescW-1:0] rd_data_o
);

  logic [DescW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [DescW-1:0] rd_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [IdxW:0]    rst_val_w;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_q <= mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_idx_i];
      rd_idx_q <= rd_idx_i;
    end
  end

  // an entry never written links to its successor
  assign rst_val_w = {1'b0, rd_idx_q} + (IdxW+1)'(1);
  assign rd_data_o = rd_vld_q ? rd_q : DescW'(rst_val_w);

endmodule
